@@ hdl/vma_pkg.sv @@
// Package for the three-axis moving average filter with flush.
// Holds field widths, register codes and reset values, the controller states and
// the controller/datapath command and status structs. Depends on nothing.
`default_nettype none

package vma_pkg;

    // Field widths
    localparam int SAMPLE_W  = 20;
    localparam int STAMP_W   = 63;
    localparam int CFG_W     = 40;
    localparam int RUN_W     = 4;
    localparam int CFG_IDX_W = 2;
    localparam int QUO_W     = SAMPLE_W;
    localparam int AXES      = 3;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_FILTER_ENABLE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GAP_LIMIT     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_JUMP_THRESH   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_JUMP_RUN      = 2'd3;

    // Configuration reset values
    localparam logic             RST_FILTER_ENABLE = 1'b1;
    localparam logic [CFG_W-1:0] RST_GAP_LIMIT     = 40'd1000000000;
    localparam logic [CFG_W-1:0] RST_JUMP_THRESH   = 40'd16384;
    localparam logic [RUN_W-1:0] RST_JUMP_RUN      = 4'd5;

    // Controller states
    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_JUMP,
        S_UPDATE,
        S_DSTART,
        S_FILL,
        S_OUT
    } t_state;

    // Commands from controller to datapath
    typedef struct packed {
        logic cap;         // capture request, read oldest ring slot
        logic ld_stamp;    // store request timestamp as last stamp
        logic clr_primed;  // restart while filtering is off
        logic clr_run;     // gap flush clears the large-sample run
        logic upd_run;     // update the run from the jump check
        logic fill_start;  // begin a flush: clear sums, counter, slot
        logic fill_step;   // write one ring entry, add sample to sums
        logic update;      // replace oldest entry, adjust sums
        logic div_start;   // scale the sums into floor averages
        logic out_load;    // load the output register
        logic out_pass;    // output is the sample itself
        logic out_flush;   // flushed flag for this result
    } t_cmd;

    // Status from datapath to controller
    typedef struct packed {
        logic filter_en;
        logic primed;
        logic restart;
        logic gap_hit;
        logic run_hit;
        logic fill_done;
        logic out_busy;
    } t_stat;

endpackage

`default_nettype wire

@@ hdl/vma_ctrl.sv @@
// Controller of the moving average filter: request sequencing state machine.
// Depends on vma_pkg; drives the datapath only through t_cmd and reads t_stat.
`default_nettype none

module vma_ctrl
    import vma_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_in_valid,
    output logic       o_in_stall,
    input  wire t_stat i_stat,
    output t_cmd       o_cmd
);

    t_state r_state, n_state;
    logic   r_pass, n_pass;
    logic   r_flush, n_flush;

    // State and result flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_pass  <= 1'b0;
            r_flush <= 1'b0;
        end else begin
            r_state <= n_state;
            r_pass  <= n_pass;
            r_flush <= n_flush;
        end
    end

    assign o_in_stall = (r_state != S_IDLE);

    // Next state and commands
    always_comb begin
        n_state = r_state;
        n_pass  = r_pass;
        n_flush = r_flush;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.cap = 1'b1;
                    n_state   = S_CHECK;
                end
            end
            S_CHECK: begin
                if (!i_stat.filter_en) begin
                    o_cmd.clr_primed = i_stat.restart;
                    n_pass  = 1'b1;
                    n_flush = 1'b0;
                    n_state = S_OUT;
                end else begin
                    o_cmd.ld_stamp = 1'b1;
                    if (!i_stat.primed || i_stat.restart) begin
                        o_cmd.fill_start = 1'b1;
                        n_pass  = 1'b1;
                        n_flush = 1'b1;
                        n_state = S_FILL;
                    end else if (i_stat.gap_hit) begin
                        o_cmd.clr_run    = 1'b1;
                        o_cmd.fill_start = 1'b1;
                        n_pass  = 1'b1;
                        n_flush = 1'b1;
                        n_state = S_FILL;
                    end else begin
                        n_state = S_JUMP;
                    end
                end
            end
            S_JUMP: begin
                o_cmd.upd_run = 1'b1;
                if (i_stat.run_hit) begin
                    o_cmd.fill_start = 1'b1;
                    n_pass  = 1'b1;
                    n_flush = 1'b1;
                    n_state = S_FILL;
                end else begin
                    n_state = S_UPDATE;
                end
            end
            S_UPDATE: begin
                o_cmd.update = 1'b1;
                n_state      = S_DSTART;
            end
            S_DSTART: begin
                o_cmd.div_start = 1'b1;
                n_pass  = 1'b0;
                n_flush = 1'b0;
                n_state = S_OUT;
            end
            S_FILL: begin
                o_cmd.fill_step = 1'b1;
                if (i_stat.fill_done) begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                o_cmd.out_pass  = r_pass;
                o_cmd.out_flush = r_flush;
                if (!i_stat.out_busy) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

@@ hdl/vma_dp.sv @@
// Datapath of the moving average filter: config registers, ring memory, sums,
// distance check, reciprocal floor scaling and output register.
// Depends on vma_pkg; controlled through t_cmd, reports through t_stat.
`default_nettype none

module vma_dp
    import vma_pkg::*;
#(
    parameter int WINDOW_LEN = 8
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    // configuration
    input  wire logic                       i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]       i_cfg_index,
    input  wire logic [CFG_W-1:0]           i_cfg_data,
    // request fields
    input  wire logic signed [SAMPLE_W-1:0] i_axis_x,
    input  wire logic signed [SAMPLE_W-1:0] i_axis_y,
    input  wire logic signed [SAMPLE_W-1:0] i_axis_z,
    input  wire logic [STAMP_W-1:0]         i_stamp_ns,
    input  wire logic                       i_restart,
    // result
    output logic                            o_out_valid,
    input  wire logic                       i_out_stall,
    output logic signed [SAMPLE_W-1:0]      o_avg_x,
    output logic signed [SAMPLE_W-1:0]      o_avg_y,
    output logic signed [SAMPLE_W-1:0]      o_avg_z,
    output logic                            o_flushed,
    // controller link
    input  wire t_cmd                       i_cmd,
    output t_stat                           o_stat
);

    localparam int ADDR_W = $clog2(WINDOW_LEN);
    localparam int SUM_W  = SAMPLE_W + ADDR_W;
    localparam int CNT_W  = ADDR_W;
    localparam int ENT_W  = AXES * SAMPLE_W;
    localparam int SQ_W   = 2 * SAMPLE_W + 1;
    localparam int DSUM_W = SQ_W + 2;
    // Bias that makes every sum non-negative; a multiple of the window length
    localparam logic [SUM_W:0]  OFFSET  = (SUM_W+1)'(WINDOW_LEN * (2 ** (SAMPLE_W - 1)));
    // Reciprocal of the window length, exact floor for any biased sum below 2**SUM_W
    localparam int              RCP_K   = SUM_W + ADDR_W;
    localparam logic [SUM_W:0]  RECIP   = (SUM_W+1)'(((64'd1 << RCP_K) + 64'(WINDOW_LEN)
                                                     - 64'd1) / 64'(WINDOW_LEN));

    // Configuration
    logic             r_filter_en;
    logic [CFG_W-1:0] r_gap_limit;
    logic [CFG_W-1:0] r_jump_thr;
    logic [RUN_W-1:0] r_jump_run;

    // Filter state
    logic [ENT_W-1:0]        r_ring [WINDOW_LEN];
    logic signed [SUM_W-1:0] r_sum [AXES];
    logic [ADDR_W-1:0]       r_slot;
    logic                    r_primed;
    logic [RUN_W-1:0]        r_run;
    logic [STAMP_W-1:0]      r_last;
    logic [CNT_W-1:0]        r_cnt;

    // Request and working registers
    logic signed [SAMPLE_W-1:0] r_smp [AXES];
    logic [STAMP_W-1:0]         r_stamp;
    logic                       r_restart;
    logic [ENT_W-1:0]           r_old;
    logic [SQ_W-1:0]            r_sq [AXES];
    logic [QUO_W-1:0]           r_quo [AXES];

    // Output register
    logic                       r_ovalid;
    logic signed [SAMPLE_W-1:0] r_oavg [AXES];
    logic                       r_oflush;

    // Combinational helpers
    logic signed [SAMPLE_W:0]     diff   [AXES];
    logic signed [2*SAMPLE_W+1:0] sq     [AXES];
    logic signed [SUM_W-1:0]      s_fill [AXES];
    logic signed [SUM_W-1:0]      s_upd  [AXES];
    logic [SUM_W:0]               u_full [AXES];
    logic [2*SUM_W+1:0]           prod   [AXES];
    logic [DSUM_W-1:0]            dsum;
    logic                         is_large;
    logic [RUN_W-1:0]             run_next;
    logic [STAMP_W:0]             gap_diff;
    logic [ADDR_W-1:0]            waddr;
    logic                         we;
    logic [ENT_W-1:0]             wdata;
    logic [ADDR_W-1:0]            slot_inc;

    // Per-axis arithmetic
    always_comb begin
        for (int a = 0; a < AXES; a++) begin
            diff[a]   = {r_smp[a][SAMPLE_W-1], r_smp[a]}
                      - {r_old[a*SAMPLE_W + SAMPLE_W - 1], r_old[a*SAMPLE_W +: SAMPLE_W]};
            sq[a]     = diff[a] * diff[a];
            s_fill[a] = r_sum[a] + {{ADDR_W{r_smp[a][SAMPLE_W-1]}}, r_smp[a]};
            s_upd[a]  = s_fill[a]
                      - {{ADDR_W{r_old[a*SAMPLE_W + SAMPLE_W - 1]}},
                         r_old[a*SAMPLE_W +: SAMPLE_W]};
            u_full[a] = {r_sum[a][SUM_W-1], r_sum[a]} + OFFSET;
            prod[a]   = u_full[a] * RECIP;
        end
    end

    // Jump distance against threshold and run length
    assign dsum     = {2'b00, r_sq[0]} + {2'b00, r_sq[1]} + {2'b00, r_sq[2]};
    assign is_large = (dsum > {{(DSUM_W-CFG_W){1'b0}}, r_jump_thr});
    assign run_next = is_large ? (r_run + 1'b1) : '0;

    // Time gap since the last filtered request; negative gaps never hit
    assign gap_diff = {1'b0, r_stamp} - {1'b0, r_last};

    // Ring write port
    assign slot_inc = (r_slot == ADDR_W'(WINDOW_LEN - 1)) ? '0 : (r_slot + 1'b1);
    assign we       = i_cmd.fill_step | i_cmd.update;
    assign waddr    = i_cmd.fill_step ? r_cnt[ADDR_W-1:0] : r_slot;
    assign wdata    = {r_smp[2], r_smp[1], r_smp[0]};

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_filter_en <= RST_FILTER_ENABLE;
            r_gap_limit <= RST_GAP_LIMIT;
            r_jump_thr  <= RST_JUMP_THRESH;
            r_jump_run  <= RST_JUMP_RUN;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_FILTER_ENABLE: r_filter_en <= i_cfg_data[0];
                CFG_GAP_LIMIT:     r_gap_limit <= i_cfg_data;
                CFG_JUMP_THRESH:   r_jump_thr  <= i_cfg_data;
                CFG_JUMP_RUN:      r_jump_run  <= i_cfg_data[RUN_W-1:0];
                default: ;
            endcase
        end
    end

    // Ring memory: one write port, registered read of the oldest slot
    always_ff @(posedge i_clk) begin
        if (we) begin
            r_ring[waddr] <= wdata;
        end
        if (i_cmd.cap) begin
            r_old <= r_ring[r_slot];
        end
    end

    // Filter control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot   <= '0;
            r_primed <= 1'b0;
            r_run    <= '0;
            r_last   <= '0;
            r_cnt    <= '0;
            for (int a = 0; a < AXES; a++) begin
                r_sum[a] <= '0;
            end
        end else begin
            if (i_cmd.ld_stamp) begin
                r_last <= r_stamp;
            end
            if (i_cmd.clr_primed) begin
                r_primed <= 1'b0;
            end else if (i_cmd.fill_start) begin
                r_primed <= 1'b1;
            end
            if (i_cmd.clr_run) begin
                r_run <= '0;
            end else if (i_cmd.upd_run) begin
                r_run <= o_stat.run_hit ? '0 : run_next;
            end
            if (i_cmd.fill_start) begin
                r_slot <= '0;
            end else if (i_cmd.update) begin
                r_slot <= slot_inc;
            end
            if (i_cmd.fill_start) begin
                r_cnt <= '0;
            end else if (i_cmd.fill_step) begin
                r_cnt <= r_cnt + 1'b1;
            end
            for (int a = 0; a < AXES; a++) begin
                if (i_cmd.fill_start) begin
                    r_sum[a] <= '0;
                end else if (i_cmd.fill_step) begin
                    r_sum[a] <= s_fill[a];
                end else if (i_cmd.update) begin
                    r_sum[a] <= s_upd[a];
                end
            end
        end
    end

    // Request capture, squared distances and scaled sums
    always_ff @(posedge i_clk) begin
        if (i_cmd.cap) begin
            r_smp[0]  <= i_axis_x;
            r_smp[1]  <= i_axis_y;
            r_smp[2]  <= i_axis_z;
            r_stamp   <= i_stamp_ns;
            r_restart <= i_restart;
        end
        for (int a = 0; a < AXES; a++) begin
            r_sq[a] <= sq[a][SQ_W-1:0];
            if (i_cmd.div_start) begin
                r_quo[a] <= prod[a][RCP_K +: QUO_W];
            end
        end
    end

    // Output register; the quotient carries the bias in its top bit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_ovalid <= 1'b1;
        end else if (!i_out_stall) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_oflush <= i_cmd.out_flush;
            for (int a = 0; a < AXES; a++) begin
                r_oavg[a] <= i_cmd.out_pass ? r_smp[a]
                                            : {~r_quo[a][QUO_W-1], r_quo[a][QUO_W-2:0]};
            end
        end
    end

    assign o_out_valid = r_ovalid;
    assign o_avg_x     = r_oavg[0];
    assign o_avg_y     = r_oavg[1];
    assign o_avg_z     = r_oavg[2];
    assign o_flushed   = r_oflush;

    // Status to the controller
    always_comb begin
        o_stat.filter_en = r_filter_en;
        o_stat.primed    = r_primed;
        o_stat.restart   = r_restart;
        o_stat.gap_hit   = !gap_diff[STAMP_W]
                         && (gap_diff[STAMP_W-1:0] >= {{(STAMP_W-CFG_W){1'b0}}, r_gap_limit});
        o_stat.run_hit   = (run_next >= r_jump_run);
        o_stat.fill_done = (r_cnt == CNT_W'(WINDOW_LEN - 1));
        o_stat.out_busy  = r_ovalid & i_out_stall;
    end

endmodule

`default_nettype wire

@@ hdl/vector_moving_average_with_flush_unit.sv @@
// Top level of the three-axis boxcar moving average filter with flush.
// Depends on vma_pkg, vma_ctrl and vma_dp.
//
//  channel  | direction | handshake                | payload
//  ---------+-----------+--------------------------+----------------------------------
//  request  | in        | i_in_valid / o_in_stall  | axis_x/y/z, stamp_ns, restart
//  result   | out       | o_out_valid / i_out_stall| avg_x/y/z, flushed
//  config   | in        | i_cfg_we                 | i_cfg_index, i_cfg_data
//
// One request at a time; the result shows in the same cycle as the request port opens
// again. Filtering off: check, output load. Flush: check (and jump test for a run
// flush), the one-entry-per-cycle refill of the ring memory, output load. Averaged:
// check, jump test, ring update, reciprocal scaling of the sums, output load.
// A result waits in the output register under i_out_stall; a new request is taken meanwhile.
// Synchronous active-low reset restores the configuration defaults; the ring is not
// cleared, since a flush fills it before any entry is read.
`default_nettype none

module vector_moving_average_with_flush_unit
    import vma_pkg::*;
#(
    parameter int WINDOW_LEN = 8
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]       i_cfg_index,
    input  wire logic [CFG_W-1:0]           i_cfg_data,
    input  wire logic                       i_in_valid,
    output logic                            o_in_stall,
    input  wire logic signed [SAMPLE_W-1:0] i_axis_x,
    input  wire logic signed [SAMPLE_W-1:0] i_axis_y,
    input  wire logic signed [SAMPLE_W-1:0] i_axis_z,
    input  wire logic [STAMP_W-1:0]         i_stamp_ns,
    input  wire logic                       i_restart,
    output logic                            o_out_valid,
    input  wire logic                       i_out_stall,
    output logic signed [SAMPLE_W-1:0]      o_avg_x,
    output logic signed [SAMPLE_W-1:0]      o_avg_y,
    output logic signed [SAMPLE_W-1:0]      o_avg_z,
    output logic                            o_flushed
);

    t_cmd  cmd;
    t_stat stat;

    vma_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    vma_dp #(
        .WINDOW_LEN (WINDOW_LEN)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_axis_x    (i_axis_x),
        .i_axis_y    (i_axis_y),
        .i_axis_z    (i_axis_z),
        .i_stamp_ns  (i_stamp_ns),
        .i_restart   (i_restart),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_avg_x     (o_avg_x),
        .o_avg_y     (o_avg_y),
        .o_avg_z     (o_avg_z),
        .o_flushed   (o_flushed),
        .i_cmd       (cmd),
        .o_stat      (stat)
    );

endmodule

`default_nettype wire

@@ hdl/vma_chk.sv @@
// Port-level checker for the moving average filter, bound to the top level.
// Depends on vma_pkg for field widths.
`default_nettype none

module vma_chk
    import vma_pkg::*;
(
    input wire logic                       i_clk,
    input wire logic                       i_rst_n,
    input wire logic                       i_in_valid,
    input wire logic                       o_in_stall,
    input wire logic                       o_out_valid,
    input wire logic                       i_out_stall,
    input wire logic signed [SAMPLE_W-1:0] o_avg_x,
    input wire logic signed [SAMPLE_W-1:0] o_avg_y,
    input wire logic signed [SAMPLE_W-1:0] o_avg_z,
    input wire logic                       o_flushed
);

    // One request in flight: an accepted request blocks the next cycle
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("request port open right after an accept");

    // A held result keeps its value
    a_result_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_avg_x)
            && $stable(o_avg_y) && $stable(o_avg_z) && $stable(o_flushed)))
        else $error("stalled result changed or dropped");

    // Reset empties the output register
    a_reset_empties: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    // A new result only comes out of a request in progress
    a_result_from_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(o_in_stall))
        else $error("result appeared without a request in progress");

endmodule

bind vector_moving_average_with_flush_unit vma_chk u_vma_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_avg_x     (o_avg_x),
    .o_avg_y     (o_avg_y),
    .o_avg_z     (o_avg_z),
    .o_flushed   (o_flushed)
);

`default_nettype wire
